// ===== design/pub_pkg.sv =====
package pub_pkg;

  localparam int POSITION_BITS = 16;
  localparam int CHAR_BITS     = 16;
  localparam int VALUE_BITS    = 32;
  localparam int COUNT_BITS    = 16;
  localparam int BASE_BITS     = 6;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

  localparam logic [BASE_BITS-1:0]  RADIX_MAX  = 6'd36;
  localparam logic [BASE_BITS-1:0]  BASE_RESET = 6'd10;
  localparam logic [VALUE_BITS-1:0] ALL_ONES   = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_STOPPED
  } phase_t;

  // One classified character as it travels from the front to the back.
  typedef struct packed {
    logic [BASE_BITS-1:0] digit;  // 0..35, or RADIX_MAX for a non-digit
    logic                 blank;
    logic                 plus;
    logic                 last;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] quot;
    logic [BASE_BITS-1:0]  rem;
    logic                  ok;
  } limits_t;

  // Overflow limits for each radix: all ones divided by the radix, and the remainder.
  function automatic limits_t limits_of(input logic [BASE_BITS-1:0] base);
    limits_t lim;
    lim = '{quot: '0, rem: '0, ok: 1'b1};
    case (base)
      6'd2:  lim = '{ALL_ONES / 32'd2,  6'(ALL_ONES % 32'd2),  1'b1};
      6'd3:  lim = '{ALL_ONES / 32'd3,  6'(ALL_ONES % 32'd3),  1'b1};
      6'd4:  lim = '{ALL_ONES / 32'd4,  6'(ALL_ONES % 32'd4),  1'b1};
      6'd5:  lim = '{ALL_ONES / 32'd5,  6'(ALL_ONES % 32'd5),  1'b1};
      6'd6:  lim = '{ALL_ONES / 32'd6,  6'(ALL_ONES % 32'd6),  1'b1};
      6'd7:  lim = '{ALL_ONES / 32'd7,  6'(ALL_ONES % 32'd7),  1'b1};
      6'd8:  lim = '{ALL_ONES / 32'd8,  6'(ALL_ONES % 32'd8),  1'b1};
      6'd9:  lim = '{ALL_ONES / 32'd9,  6'(ALL_ONES % 32'd9),  1'b1};
      6'd10: lim = '{ALL_ONES / 32'd10, 6'(ALL_ONES % 32'd10), 1'b1};
      6'd11: lim = '{ALL_ONES / 32'd11, 6'(ALL_ONES % 32'd11), 1'b1};
      6'd12: lim = '{ALL_ONES / 32'd12, 6'(ALL_ONES % 32'd12), 1'b1};
      6'd13: lim = '{ALL_ONES / 32'd13, 6'(ALL_ONES % 32'd13), 1'b1};
      6'd14: lim = '{ALL_ONES / 32'd14, 6'(ALL_ONES % 32'd14), 1'b1};
      6'd15: lim = '{ALL_ONES / 32'd15, 6'(ALL_ONES % 32'd15), 1'b1};
      6'd16: lim = '{ALL_ONES / 32'd16, 6'(ALL_ONES % 32'd16), 1'b1};
      6'd17: lim = '{ALL_ONES / 32'd17, 6'(ALL_ONES % 32'd17), 1'b1};
      6'd18: lim = '{ALL_ONES / 32'd18, 6'(ALL_ONES % 32'd18), 1'b1};
      6'd19: lim = '{ALL_ONES / 32'd19, 6'(ALL_ONES % 32'd19), 1'b1};
      6'd20: lim = '{ALL_ONES / 32'd20, 6'(ALL_ONES % 32'd20), 1'b1};
      6'd21: lim = '{ALL_ONES / 32'd21, 6'(ALL_ONES % 32'd21), 1'b1};
      6'd22: lim = '{ALL_ONES / 32'd22, 6'(ALL_ONES % 32'd22), 1'b1};
      6'd23: lim = '{ALL_ONES / 32'd23, 6'(ALL_ONES % 32'd23), 1'b1};
      6'd24: lim = '{ALL_ONES / 32'd24, 6'(ALL_ONES % 32'd24), 1'b1};
      6'd25: lim = '{ALL_ONES / 32'd25, 6'(ALL_ONES % 32'd25), 1'b1};
      6'd26: lim = '{ALL_ONES / 32'd26, 6'(ALL_ONES % 32'd26), 1'b1};
      6'd27: lim = '{ALL_ONES / 32'd27, 6'(ALL_ONES % 32'd27), 1'b1};
      6'd28: lim = '{ALL_ONES / 32'd28, 6'(ALL_ONES % 32'd28), 1'b1};
      6'd29: lim = '{ALL_ONES / 32'd29, 6'(ALL_ONES % 32'd29), 1'b1};
      6'd30: lim = '{ALL_ONES / 32'd30, 6'(ALL_ONES % 32'd30), 1'b1};
      6'd31: lim = '{ALL_ONES / 32'd31, 6'(ALL_ONES % 32'd31), 1'b1};
      6'd32: lim = '{ALL_ONES / 32'd32, 6'(ALL_ONES % 32'd32), 1'b1};
      6'd33: lim = '{ALL_ONES / 32'd33, 6'(ALL_ONES % 32'd33), 1'b1};
      6'd34: lim = '{ALL_ONES / 32'd34, 6'(ALL_ONES % 32'd34), 1'b1};
      6'd35: lim = '{ALL_ONES / 32'd35, 6'(ALL_ONES % 32'd35), 1'b1};
      6'd36: lim = '{ALL_ONES / 32'd36, 6'(ALL_ONES % 32'd36), 1'b1};
      default: lim = '{quot: '0, rem: '0, ok: 1'b0};
    endcase
    return lim;
  endfunction

endpackage

// ===== design/pub_front.sv =====
module pub_front (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [pub_pkg::CHAR_BITS-1:0] in_tdata,
  input  logic                          in_tlast,
  input  pub_pkg::queue_stat_t          stat,
  output logic                          push,
  output pub_pkg::item_t                push_item
);

  logic [pub_pkg::BASE_BITS-1:0] digit;

  // Decimal digits and letters of either case; everything else is a non-digit.
  always_comb begin
    digit = pub_pkg::RADIX_MAX;
    if (in_tdata >= 16'h0030 && in_tdata <= 16'h0039) begin
      digit = 6'(in_tdata - 16'h0030);
    end else if (in_tdata >= 16'h0061 && in_tdata <= 16'h007A) begin
      digit = 6'(in_tdata - 16'h0057);
    end else if (in_tdata >= 16'h0041 && in_tdata <= 16'h005A) begin
      digit = 6'(in_tdata - 16'h0037);
    end
  end

  assign in_tready       = !stat.full;
  assign push            = in_tvalid && !stat.full;
  assign push_item.digit = digit;
  assign push_item.blank = (in_tdata == 16'h0020) || (in_tdata == 16'h0009);
  assign push_item.plus  = (in_tdata == 16'h002B);
  assign push_item.last  = in_tlast;

endmodule

// ===== design/pub_queue.sv =====
module pub_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pub_pkg::item_t       push_item,
  input  logic                 pop,
  output pub_pkg::item_t       pop_item,
  output pub_pkg::queue_stat_t stat
);

  pub_pkg::item_t                 mem [pub_pkg::QUEUE_DEPTH];
  logic [pub_pkg::QPTR_BITS-1:0]  wr_ptr_r, rd_ptr_r;
  logic [pub_pkg::QPTR_BITS:0]    count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign pop_item   = mem[rd_ptr_r];
  assign stat.full  = (count_r == (pub_pkg::QPTR_BITS+1)'(pub_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

`ifndef ASSERT_OFF
  a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    count_r[pub_pkg::QPTR_BITS-1:0] == (wr_ptr_r - rd_ptr_r)
    && count_r <= (pub_pkg::QPTR_BITS+1)'(pub_pkg::QUEUE_DEPTH))
    else $error("queue fill count disagrees with pointers");
`endif

endmodule

// ===== design/pub_back.sv =====
module pub_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wen,
  input  logic [pub_pkg::BASE_BITS-1:0] cfg_wdata,
  input  pub_pkg::item_t                pop_item,
  input  pub_pkg::queue_stat_t          stat,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [63:0]                   out_tdata
);

  localparam logic [pub_pkg::POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [pub_pkg::COUNT_BITS-1:0]    DIG_MAX = '1;

  logic [pub_pkg::BASE_BITS-1:0]     base_r;
  pub_pkg::limits_t                  lim_r;
  pub_pkg::phase_t                   phase_r, phase_step, phase_nxt;
  logic [pub_pkg::VALUE_BITS-1:0]    acc_r, acc_step;
  logic [pub_pkg::POSITION_BITS-1:0] pos_r, pos_step;
  logic [pub_pkg::COUNT_BITS-1:0]    dig_r, dig_step;

  logic                              out_valid_r;
  logic [pub_pkg::VALUE_BITS-1:0]    out_value_r, out_value_nxt;
  logic [pub_pkg::COUNT_BITS-1:0]    out_offset_r, out_offset_nxt;
  logic [pub_pkg::COUNT_BITS-1:0]    out_count_r, out_count_nxt;

  logic                              step, skip_blank, skip_plus, is_digit, ovf;
  logic                              adv, dig_inc;
  logic [pub_pkg::VALUE_BITS+pub_pkg::BASE_BITS-1:0] prod;
  logic [pub_pkg::VALUE_BITS-1:0]    mac;

  assign pop  = !stat.empty && (!out_valid_r || out_tready);
  assign step = pop && lim_r.ok && (phase_r != pub_pkg::PH_STOPPED);

  assign skip_blank = (phase_r == pub_pkg::PH_SKIP) && pop_item.blank;
  assign skip_plus  = (phase_r == pub_pkg::PH_SKIP) && pop_item.plus;
  assign is_digit   = pop_item.digit < base_r;
  assign ovf        = (acc_r > lim_r.quot)
                      || ((acc_r == lim_r.quot) && (pop_item.digit > lim_r.rem));
  assign prod       = acc_r * base_r;
  assign mac        = pub_pkg::VALUE_BITS'(prod)
                      + {{(pub_pkg::VALUE_BITS-pub_pkg::BASE_BITS){1'b0}}, pop_item.digit};

  // Phase transitions.
  always_comb begin
    phase_step = phase_r;
    if (step) begin
      if (skip_blank) begin
        phase_step = phase_r;
      end else if (skip_plus) begin
        phase_step = pub_pkg::PH_DIGITS;
      end else if (!is_digit || ovf) begin
        phase_step = pub_pkg::PH_STOPPED;
      end else begin
        phase_step = pub_pkg::PH_DIGITS;
      end
    end
    phase_nxt = (pop && pop_item.last) ? pub_pkg::PH_SKIP : phase_step;
  end

  // Field datapath and result values.
  always_comb begin
    dig_inc  = step && !skip_blank && !skip_plus && is_digit;
    adv      = step && (skip_blank || skip_plus || (dig_inc && !ovf));
    acc_step = (dig_inc && !ovf) ? mac : acc_r;
    pos_step = (adv && pos_r != POS_MAX) ? pos_r + 1'b1 : pos_r;
    dig_step = (dig_inc && dig_r != DIG_MAX) ? dig_r + 1'b1 : dig_r;
    if (lim_r.ok) begin
      out_value_nxt  = acc_step;
      out_offset_nxt = (dig_step == '0) ? '0 : pub_pkg::COUNT_BITS'(pos_step);
      out_count_nxt  = dig_step;
    end else begin
      out_value_nxt  = '0;
      out_offset_nxt = '0;
      out_count_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= pub_pkg::BASE_RESET;
      lim_r       <= pub_pkg::limits_of(pub_pkg::BASE_RESET);
      phase_r     <= pub_pkg::PH_SKIP;
      acc_r       <= '0;
      pos_r       <= '0;
      dig_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        base_r <= cfg_wdata;
        lim_r  <= pub_pkg::limits_of(cfg_wdata);
      end
      phase_r <= phase_nxt;
      if (pop && pop_item.last) begin
        acc_r <= '0;
        pos_r <= '0;
        dig_r <= '0;
      end else begin
        acc_r <= acc_step;
        pos_r <= pos_step;
        dig_r <= dig_step;
      end
      if (pop && pop_item.last) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_item.last) begin
      out_value_r  <= out_value_nxt;
      out_offset_r <= out_offset_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_offset_r, out_value_r};

`ifndef ASSERT_OFF
  a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == pub_pkg::PH_SKIP |-> (acc_r == '0 && dig_r == '0))
    else $error("field state not clear while skipping blanks");
  a_no_digit_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    dig_r == '0 |-> acc_r == '0)
    else $error("value accumulated without any digit");
  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_count_r == '0 |-> out_offset_r == '0)
    else $error("nonzero stop offset reported with no digits");
`endif

endmodule

// ===== design/parse_unsigned_in_base.sv =====
// Streaming text-to-unsigned parser in the manner of strtoul.
// The input channel carries one character per beat: in_tdata holds the
// character code and in_tlast marks the last character of a field.
// Leading spaces and tabs are skipped, one optional plus sign is taken,
// and digits of the configured radix (2 to 36, letters in either case for
// 10 to 35) are accumulated until a non-digit or a digit that would carry
// the value past 32 bits. One result beat leaves on out_tdata for every
// input beat with in_tlast set; other beats produce no result.
// The radix is written through cfg_wen/cfg_wdata; the user must do so only
// while the block is idle, as the block does not enforce it. Its overflow
// limits come from a constant table and are registered at the write. A
// radix outside 2 to 36 makes every field report all zeros. Throughput is
// one character per cycle unless a result waits on out_tready. A character
// is classified and written into a four-entry queue at acceptance; the back
// end pops it and does the multiply-accumulate and limit compare on it. When
// out_tready is low the result holds in the output register and the queue
// absorbs up to four characters before in_tready drops. Reset clears the
// field state and the queue and sets the radix to ten.
module parse_unsigned_in_base (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [5:0]  cfg_wdata,   // number_base
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] char_code
  input  logic        in_tlast,    // field_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata    // [31:0] parsed_value, [47:32] stop_offset,
                                   // [63:48] digit_count
);

  pub_pkg::item_t       push_item, pop_item;
  pub_pkg::queue_stat_t stat;
  logic                 push, pop;

  // Front end: classifies each character as it is accepted.
  pub_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .stat      (stat),
    .push      (push),
    .push_item (push_item)
  );

  // Short queue decoupling the front end from the parse engine.
  pub_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (stat)
  );

  // Back end: parse state machine, accumulator and output register.
  pub_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .pop_item   (pop_item),
    .stat       (stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== dv/tb.sv =====
module tb;

  // Character codes that the parser treats specially.
  localparam logic [15:0] CH_TAB     = 16'h0009;
  localparam logic [15:0] CH_SPACE   = 16'h0020;
  localparam logic [15:0] CH_PLUS    = 16'h002B;
  localparam logic [15:0] CH_MINUS   = 16'h002D;
  localparam logic [15:0] CH_ZERO    = 16'h0030;
  localparam logic [15:0] CH_UPPER_A = 16'h0041;
  localparam logic [15:0] CH_LOWER_A = 16'h0061;

  // Quiet cycles after the last result before the radix may change. The
  // block holds up to four characters in its queue and one result in its
  // output register, so this covers a field still in flight.
  localparam int SETTLE_CYCLES    = 12;
  localparam int RANDOM_ITEMS     = 300;
  localparam int STEADY_FIELDS    = 20;
  localparam int MAX_PRINTED      = 40;

  typedef logic [15:0] char_q_t[$];

  // Same layout as out_tdata, lowest field last.
  typedef struct packed {
    logic [15:0] count;
    logic [15:0] offset;
    logic [31:0] value;
  } parse_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_wen    = 1'b0;
  logic [5:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;

  // Our own copy of the parser state, advanced on every accepted input beat.
  logic [pub_pkg::BASE_BITS-1:0]     radix      = pub_pkg::BASE_RESET;
  logic [31:0]                       quot_limit = 32'hFFFF_FFFF / 32'd10;
  logic [5:0]                        rem_limit  = 6'd5;
  pub_pkg::phase_t                   phase      = pub_pkg::PH_SKIP;
  logic [31:0]                       acc        = '0;
  logic [pub_pkg::POSITION_BITS-1:0] position   = '0;
  logic [15:0]                       digits     = '0;

  parse_result_t pending_results[$];
  int            mismatch_count = 0;
  int            items_sent     = 0;
  // While set, neither side idles: this gives a long back-to-back stretch.
  bit            steady         = 1'b0;

  parse_unsigned_in_base dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial forever #4 clk = ~clk;

  // The run is bounded well above the slowest legal run.
  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Unless steady is set, out_tready is low at random with a chance of about 18 in a hundred.
  always @(posedge clk) out_tready <= steady || ($urandom_range(0, 99) >= 18);

  function automatic bit radix_ok(input logic [pub_pkg::BASE_BITS-1:0] b);
    return b >= 6'd2 && b <= pub_pkg::RADIX_MAX;
  endfunction

  // Digit value of a character, or RADIX_MAX when it is no digit at all.
  // Only plain ASCII digits and letters count; wide codes never do.
  function automatic logic [5:0] digit_value(input logic [15:0] code);
    if (code >= CH_ZERO && code <= CH_ZERO + 16'd9)
      return 6'(code - CH_ZERO);
    if (code >= CH_LOWER_A && code <= CH_LOWER_A + 16'd25)
      return 6'(code - CH_LOWER_A + 16'd10);
    if (code >= CH_UPPER_A && code <= CH_UPPER_A + 16'd25)
      return 6'(code - CH_UPPER_A + 16'd10);
    return pub_pkg::RADIX_MAX;
  endfunction

  // Character for a digit value; letters come in either case at random.
  function automatic logic [15:0] digit_char(input logic [5:0] d);
    if (d < 6'd10)
      return CH_ZERO + 16'(d);
    return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 16'(d - 6'd10);
  endfunction

  // Advances the parse by one character and, on the last character of a
  // field, queues the result that the block must report.
  function automatic void parse_char(input logic [15:0] code, input logic last);
    logic [5:0]    d;
    parse_result_t res;
    if (radix_ok(radix) && phase != pub_pkg::PH_STOPPED) begin
      if (phase == pub_pkg::PH_SKIP && (code == CH_SPACE || code == CH_TAB)) begin
        if (position != '1) position++;
      end else if (phase == pub_pkg::PH_SKIP && code == CH_PLUS) begin
        phase = pub_pkg::PH_DIGITS;
        if (position != '1) position++;
      end else begin
        d = digit_value(code);
        phase = pub_pkg::PH_DIGITS;
        if (d >= radix) begin
          phase = pub_pkg::PH_STOPPED;
        end else begin
          // A digit that would overflow is counted but not taken.
          if (digits != 16'hFFFF) digits++;
          if (acc > quot_limit || (acc == quot_limit && d > rem_limit)) begin
            phase = pub_pkg::PH_STOPPED;
          end else begin
            acc = acc * 32'(radix) + 32'(d);
            if (position != '1) position++;
          end
        end
      end
    end
    if (last) begin
      if (radix_ok(radix)) begin
        res.value  = acc;
        res.offset = (digits == 0) ? 16'd0 : 16'(position);
        res.count  = digits;
      end else begin
        res = '0;
      end
      pending_results.push_back(res);
      phase    = pub_pkg::PH_SKIP;
      acc      = '0;
      position = '0;
      digits   = '0;
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Both channels are sampled at the clock edge. A result beat is checked
  // before the input beat of the same edge is parsed; a result can never
  // come from a character accepted at the same edge.
  always @(posedge clk) begin : watch_beats
    parse_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %h with none expected", out_tdata));
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[31:0] !== want.value)
            report_mismatch($sformatf("parsed_value %h, expected %h",
                                      out_tdata[31:0], want.value));
          if (out_tdata[47:32] !== want.offset)
            report_mismatch($sformatf("stop_offset %0d, expected %0d",
                                      out_tdata[47:32], want.offset));
          if (out_tdata[63:48] !== want.count)
            report_mismatch($sformatf("digit_count %0d, expected %0d",
                                      out_tdata[63:48], want.count));
        end
      end
      if (in_tvalid && in_tready)
        parse_char(in_tdata, in_tlast);
    end
  end

  // Sends one character beat and returns at the edge that accepts it. The
  // sender idles before about one beat in ten unless steady is set.
  task automatic send_char(input logic [15:0] code, input logic last);
    if (!steady && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Sends a run of characters; with close set the final one ends the field.
  task automatic send_field(input char_q_t codes, input bit close = 1'b1);
    foreach (codes[i])
      send_char(codes[i], close && (i == codes.size() - 1));
  endtask

  task automatic send_text(input string s, input bit close = 1'b1);
    char_q_t codes;
    for (int i = 0; i < s.len(); i++)
      codes.push_back({8'h00, s[i]});
    send_field(codes, close);
  endtask

  // Stops sending, waits for every expected result and lets the block's
  // queue drain. The first edge lets the last accepted beat be parsed.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The radix is written only once the block has gone quiet. Our copy and
  // its overflow limits change with it.
  task automatic set_radix(input logic [pub_pkg::BASE_BITS-1:0] b);
    settle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    radix = b;
    if (radix_ok(b)) begin
      quot_limit = 32'hFFFF_FFFF / 32'(b);
      rem_limit  = 6'(32'hFFFF_FFFF % 32'(b));
    end else begin
      quot_limit = '0;
      rem_limit  = '0;
    end
  endtask

  // The largest value in the given radix. Variant 1 adds one more digit, so
  // the value is already above the quotient limit; variant 2 raises the
  // final digit past the remainder limit where the radix leaves room.
  function automatic char_q_t max_field(input logic [5:0] b, input int variant);
    char_q_t    f;
    logic [31:0] v;
    logic [5:0]  d;
    v = 32'hFFFF_FFFF;
    while (v != 0) begin
      f.push_front(digit_char(6'(v % 32'(b))));
      v = v / 32'(b);
    end
    if (variant == 1) begin
      f.push_back(digit_char(6'($urandom_range(0, b - 1))));
    end else if (variant == 2) begin
      d = digit_value(f[$]);
      if (d + 6'd1 < b)
        f[$] = digit_char(6'($urandom_range(d + 1, b - 1)));
    end
    return f;
  endfunction

  // Mostly well-formed fields (blanks, an optional sign, digits of the
  // radix, junk after them at times), max_field values or random codes.
  function automatic char_q_t random_field(input logic [5:0] b);
    char_q_t f;
    int      kind;
    int      top;
    kind = $urandom_range(0, 99);
    top  = radix_ok(b) ? b - 1 : 35;
    if (kind < 15) begin
      repeat ($urandom_range(1, 6))
        f.push_back($urandom_range(0, 2) == 0 ? 16'($urandom)
                                               : 16'($urandom_range(9, 126)));
    end else if (kind < 25 && radix_ok(b)) begin
      f = max_field(b, $urandom_range(0, 2));
    end else begin
      repeat ($urandom_range(0, 2))
        f.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      if ($urandom_range(0, 3) == 0) f.push_back(CH_PLUS);
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10))
        f.push_back(digit_char(6'($urandom_range(0, top))));
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) f.push_back(16'($urandom_range(32, 126)));
    end
    return f;
  endfunction

  // Base ten straight out of reset: largest value, both ways of
  // overflowing, blanks and sign, a lone sign, a second sign, a sign after
  // digits, a minus, and fields with no digit at all.
  task automatic test_reset_radix();
    send_text("0");
    send_text("4294967295");
    send_text("4294967296");
    send_text("99999999999");
    send_text(" \t+123xyz");
    send_text("+");
    send_text(" \t");
    send_text("++5");
    send_text("12+3");
    send_text("007 8");
    send_field('{CH_MINUS, CH_ZERO + 16'd5});
  endtask

  // Letters in both cases, the codes that border digits and letters, and
  // control or wide codes that only look like digits in their low bits.
  task automatic test_letters_and_codes();
    set_radix(pub_pkg::RADIX_MAX);
    send_text("zZ1");
    send_text("Az/");
    send_text(":@[`{");
    send_field('{16'h0011, 16'h0019});
    send_field('{16'h8031, 16'hFF41});
    send_field('{16'hFFFF});
    set_radix(6'd16);
    send_text("fFg");
  endtask

  // Every radix value once, the invalid ones included, with a random
  // field in each; valid ones add the largest value or an overflow form.
  task automatic test_radix_sweep();
    for (int b = 0; b < 64; b++) begin
      set_radix(6'(b));
      if (radix_ok(6'(b)))
        send_field(max_field(6'(b), $urandom_range(0, 2)));
      send_field(random_field(6'(b)));
    end
  endtask

  // A radix written between characters of one field applies from the next
  // character on, including a switch to an invalid radix.
  task automatic test_mid_field_radix();
    set_radix(6'd10);
    send_text(" +12", 1'b0);
    set_radix(6'd16);
    send_text("aFg");
    send_text("77", 1'b0);
    set_radix(6'd40);
    send_text("7");
    send_text("19", 1'b0);
    set_radix(6'd8);
    send_text("789");
  endtask

  task automatic test_random_fields();
    int stop_at;
    int pick;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)
          set_radix(6'($urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(37, 63)));
        else if (pick == 1)
          set_radix($urandom_range(0, 1) ? 6'd2 : pub_pkg::RADIX_MAX);
        else
          set_radix(6'($urandom_range(2, 36)));
      end
      send_field(random_field(radix));
    end
  endtask

  // Neither side idles here, so beats follow each other on every cycle.
  task automatic test_back_to_back();
    set_radix(6'd10);
    steady = 1'b1;
    repeat (STEADY_FIELDS) send_field(random_field(radix));
    settle();
    steady = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_radix();
    test_letters_and_codes();
    test_radix_sweep();
    test_mid_field_radix();
    test_back_to_back();
    test_random_fields();
    settle();
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
